@@ sv/textured_span_interpolator_assert.svh @@
// ---------------------------------------------------------------------------
// Span walker assertion macros
// Shared property forms for the span walker checks; clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef TEXTURED_SPAN_INTERPOLATOR_ASSERT_SVH
`define TEXTURED_SPAN_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define TSI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("span walker check failed");

// Next-cycle implication, disabled in reset
`define TSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("span walker check failed");

`endif

@@ sv/tsi_pkg.sv @@
// ---------------------------------------------------------------------------
// Span walker package
// Types and fixed constants shared by the span walker modules.
// ---------------------------------------------------------------------------
package tsi_pkg;

  localparam int FIX_BITS      = 32;
  localparam int FIX_FRAC_BITS = 16;
  localparam int INT_BITS      = FIX_BITS - FIX_FRAC_BITS;
  localparam int SIZE_BITS     = 13;
  localparam int LIM_BITS      = 2 * SIZE_BITS;
  localparam int WLOG_BITS     = 4;
  localparam int SCR_BITS      = 12;

  localparam logic [SIZE_BITS-1:0] SCREEN_END = 13'd4096;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_U_STEP      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_V_STEP      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_STEP  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PITCH   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TEX_HEIGHT  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH_LOG2  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_WRAP_EN     = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_DITHER_EN   = 3'd7;

  // Addressing setup handed to the offset unit
  typedef struct packed {
    logic                 wrap;
    logic [WLOG_BITS-1:0] wlog;
    logic [SIZE_BITS-1:0] pitch;   // zero already mapped to one
    logic [SIZE_BITS-1:0] hmask;   // height minus one
    logic [LIM_BITS-1:0]  lim;     // height times pitch
  } tsi_addr_cfg_t;

endpackage

@@ sv/textured_span_interpolator.sv @@
// ---------------------------------------------------------------------------
// Textured span interpolator
// Walks a horizontal span of an affine lit texture, one pixel per clock while out_stall is low.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_stall  | mode, x_start, x_end, row_y, u/v/light_start
//  out     | out_valid/out_stall| texel_offset, light_value, pixel_x/y, last
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
//  One transaction per clock sustained while out_stall is low; a transaction
//  passes the input register, then the result register. The span state and
//  the offset multiply sit between those two registers.
//  rst_n is synchronous; it clears valids, the span flag and configuration (row pitch and height reset to one).
//  A stalled result holds; the input register keeps taking one more
//  transaction before in_stall rises.
// ---------------------------------------------------------------------------
`include "textured_span_interpolator_assert.svh"

module textured_span_interpolator #(
  parameter int COORD_BITS  = 12,
  parameter int OFFSET_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tsi_pkg::FIX_BITS-1:0]        cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic [11:0]                         in_x_start,
  input  logic [12:0]                         in_x_end,
  input  logic [11:0]                         in_row_y,
  input  logic signed [31:0]                  in_u_start,
  input  logic signed [31:0]                  in_v_start,
  input  logic signed [31:0]                  in_light_start,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [OFFSET_BITS-1:0]              out_texel_offset,
  output logic signed [31:0]                  out_light_value,
  output logic [COORD_BITS-1:0]               out_pixel_x,
  output logic [COORD_BITS-1:0]               out_pixel_y,
  output logic                                out_last
);
  import tsi_pkg::*;

  // configuration registers
  logic [FIX_BITS-1:0]  u_step_r, v_step_r, light_step_r;
  logic [SIZE_BITS-1:0] row_pitch_r, tex_height_r;
  logic [WLOG_BITS-1:0] width_log2_r;
  logic                 wrap_enable_r, dither_enable_r;
  logic [LIM_BITS-1:0]  lim;
  logic [SIZE_BITS-1:0] pitch_eff, height_eff;
  tsi_addr_cfg_t        addr_cfg;

  // input register
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_mode_r;
  logic [SCR_BITS-1:0]  s1_x_start_r, s1_row_y_r;
  logic [SIZE_BITS-1:0] s1_x_end_r;
  logic [FIX_BITS-1:0]  s1_u_r, s1_v_r, s1_light_r;

  // span state
  logic [FIX_BITS-1:0]      cur_u_r, cur_v_r, cur_light_r;
  logic [FIX_BITS-1:0]      cur_u_nxt, cur_v_nxt, cur_light_nxt;
  logic [FIX_FRAC_BITS-1:0] dither_err_r, dither_err_nxt;
  logic [SIZE_BITS-1:0]     cur_x_r, cur_x_nxt, end_x_r;
  logic [SCR_BITS-1:0]      cur_row_r;
  logic                     span_active_r, span_active_nxt;

  // per-pixel working values
  logic [SIZE_BITS-1:0]     xe_sat, eff_x, eff_end;
  logic [SCR_BITS-1:0]      eff_row;
  logic [FIX_BITS-1:0]      eff_u, eff_v, eff_light;
  logic [FIX_FRAC_BITS-1:0] eff_err;
  logic                     eff_active, is_last;
  logic [OFFSET_BITS-1:0]   texel_off;

  // result register
  logic                     out_valid_r;
  logic [OFFSET_BITS-1:0]   out_texel_offset_r;
  logic [FIX_BITS-1:0]      out_light_value_r;
  logic [COORD_BITS-1:0]    out_pixel_x_r, out_pixel_y_r;
  logic                     out_last_r;

  logic out_free, s1_adv, in_accept;

  // ---- handshake ----
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  // ---- configuration ----
  assign pitch_eff  = (row_pitch_r  == '0) ? SIZE_BITS'(1) : row_pitch_r;
  assign height_eff = (tex_height_r == '0) ? SIZE_BITS'(1) : tex_height_r;
  assign lim        = {{SIZE_BITS{1'b0}}, height_eff} * {{SIZE_BITS{1'b0}}, pitch_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_step_r        <= '0;
      v_step_r        <= '0;
      light_step_r    <= '0;
      row_pitch_r     <= SIZE_BITS'(1);
      tex_height_r    <= SIZE_BITS'(1);
      width_log2_r    <= '0;
      wrap_enable_r   <= 1'b0;
      dither_enable_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_U_STEP:     u_step_r        <= cfg_data;
          REG_V_STEP:     v_step_r        <= cfg_data;
          REG_LIGHT_STEP: light_step_r    <= cfg_data;
          REG_ROW_PITCH:  row_pitch_r     <= cfg_data[SIZE_BITS-1:0];
          REG_TEX_HEIGHT: tex_height_r    <= cfg_data[SIZE_BITS-1:0];
          REG_WIDTH_LOG2: width_log2_r    <= cfg_data[WLOG_BITS-1:0];
          REG_WRAP_EN:    wrap_enable_r   <= cfg_data[0];
          REG_DITHER_EN:  dither_enable_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  assign addr_cfg.wrap  = wrap_enable_r;
  assign addr_cfg.wlog  = width_log2_r;
  assign addr_cfg.pitch = pitch_eff;
  assign addr_cfg.hmask = height_eff - SIZE_BITS'(1);
  assign addr_cfg.lim   = lim;

  // ---- input register ----
  assign s1_valid_nxt = in_accept || (s1_valid_r && !out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r    <= in_mode;
      s1_x_start_r <= in_x_start;
      s1_x_end_r   <= in_x_end;
      s1_row_y_r   <= in_row_y;
      s1_u_r       <= in_u_start;
      s1_v_r       <= in_v_start;
      s1_light_r   <= in_light_start;
    end
  end

  // ---- pixel step ----
  always_comb begin
    xe_sat     = (s1_x_end_r > SCREEN_END) ? SCREEN_END : s1_x_end_r;
    // a start transaction replaces the span state
    eff_x      = s1_mode_r ? {1'b0, s1_x_start_r} : cur_x_r;
    eff_end    = s1_mode_r ? xe_sat               : end_x_r;
    eff_row    = s1_mode_r ? s1_row_y_r           : cur_row_r;
    eff_u      = s1_mode_r ? s1_u_r               : cur_u_r;
    eff_v      = s1_mode_r ? s1_v_r               : cur_v_r;
    eff_light  = s1_mode_r ? s1_light_r           : cur_light_r;
    eff_err    = s1_mode_r ? '0                   : dither_err_r;
    eff_active = s1_mode_r ? ({1'b0, s1_x_start_r} < xe_sat) : span_active_r;
    is_last    = ({1'b0, eff_x} + (SIZE_BITS+1)'(1)) >= {1'b0, eff_end};

    if (eff_active) begin
      cur_u_nxt     = eff_u + u_step_r;
      cur_v_nxt     = eff_v + v_step_r;
      cur_light_nxt = eff_light + light_step_r;
      dither_err_nxt = dither_enable_r ? (eff_err + cur_light_nxt[FIX_FRAC_BITS-1:0]) : '0;
      cur_x_nxt     = eff_x + SIZE_BITS'(1);
    end else begin
      cur_u_nxt      = eff_u;
      cur_v_nxt      = eff_v;
      cur_light_nxt  = eff_light;
      dither_err_nxt = eff_err;
      cur_x_nxt      = eff_x;
    end
    span_active_nxt = eff_active && !is_last;
  end

  tsi_addr #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_addr (
    .cfg_i    (addr_cfg),
    .u_i      (eff_u),
    .v_i      (eff_v),
    .offset_o (texel_off)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_active_r <= 1'b0;
    end else if (s1_adv) begin
      span_active_r <= span_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      cur_u_r      <= cur_u_nxt;
      cur_v_r      <= cur_v_nxt;
      cur_light_r  <= cur_light_nxt;
      dither_err_r <= dither_err_nxt;
      cur_x_r      <= cur_x_nxt;
      end_x_r      <= eff_end;
      cur_row_r    <= eff_row;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && eff_active;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && eff_active) begin
      out_texel_offset_r <= texel_off;
      out_light_value_r  <= eff_light + {{(FIX_BITS-FIX_FRAC_BITS){1'b0}}, eff_err};
      out_pixel_x_r      <= COORD_BITS'(eff_x[SCR_BITS-1:0]);
      out_pixel_y_r      <= COORD_BITS'(eff_row);
      out_last_r         <= is_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_texel_offset = out_texel_offset_r;
  assign out_light_value  = out_light_value_r;
  assign out_pixel_x      = out_pixel_x_r;
  assign out_pixel_y      = out_pixel_y_r;
  assign out_last         = out_last_r;

  // ---- checks ----
  `TSI_ASSERT_NEXT(a_last_ends_span, s1_adv && eff_active && is_last, !span_active_r)
  `TSI_ASSERT_NEXT(a_x_advances, s1_adv && eff_active && !is_last, span_active_r && (cur_x_r == $past(eff_x) + SIZE_BITS'(1)))
  `TSI_ASSERT_NEXT(a_clamp_in_range, s1_adv && eff_active && !wrap_enable_r, 32'(out_texel_offset_r) < 32'($past(lim)))

endmodule

@@ sv/tsi_addr.sv @@
// ---------------------------------------------------------------------------
// Texel offset unit
// Maps 16.16 u and v to a texel offset, clamped linear or wrapped.
// ---------------------------------------------------------------------------
module tsi_addr #(
  parameter int OFFSET_BITS = 24
) (
  input  tsi_pkg::tsi_addr_cfg_t      cfg_i,
  input  logic [tsi_pkg::FIX_BITS-1:0] u_i,
  input  logic [tsi_pkg::FIX_BITS-1:0] v_i,
  output logic [OFFSET_BITS-1:0]      offset_o
);
  import tsi_pkg::*;

  logic signed [INT_BITS-1:0]            ui;
  logic signed [INT_BITS-1:0]            vi;
  logic signed [INT_BITS+SIZE_BITS:0]    prod;
  logic signed [FIX_BITS-1:0]            lin;
  logic [FIX_BITS-1:0]                   clamp_off;
  logic [INT_BITS-1:0]                   vw;
  logic [INT_BITS-1:0]                   uw;
  logic [FIX_BITS-1:0]                   wrap_off;
  logic [FIX_BITS-1:0]                   off;

  always_comb begin
    ui   = $signed(u_i[FIX_BITS-1:FIX_FRAC_BITS]);
    vi   = $signed(v_i[FIX_BITS-1:FIX_FRAC_BITS]);
    prod = (INT_BITS+SIZE_BITS+1)'(vi)
         * (INT_BITS+SIZE_BITS+1)'($signed({1'b0, cfg_i.pitch}));
    lin  = $signed({{(FIX_BITS-INT_BITS-SIZE_BITS-1){prod[INT_BITS+SIZE_BITS]}}, prod})
         + $signed({{(FIX_BITS-INT_BITS){ui[INT_BITS-1]}}, ui});
    // Out of the texture, negative included, reads texel zero
    if (lin[FIX_BITS-1] ||
        (lin[FIX_BITS-2:0] >= {{(FIX_BITS-1-LIM_BITS){1'b0}}, cfg_i.lim})) begin
      clamp_off = '0;
    end else begin
      clamp_off = lin;
    end

    vw       = v_i[FIX_BITS-1:FIX_FRAC_BITS] & {{(INT_BITS-SIZE_BITS){1'b0}}, cfg_i.hmask};
    uw       = u_i[FIX_BITS-1:FIX_FRAC_BITS] & ~({INT_BITS{1'b1}} << cfg_i.wlog);
    wrap_off = ({{(FIX_BITS-INT_BITS){1'b0}}, vw} << cfg_i.wlog)
             + {{(FIX_BITS-INT_BITS){1'b0}}, uw};

    off      = cfg_i.wrap ? wrap_off : clamp_off;
    offset_o = off[OFFSET_BITS-1:0];
  end

endmodule
